@@ hw/rtl/pfs_pkg.sv @@
// Shared constants, codes and control types for the page frame free stack.
// No dependencies; imported by the controller, the datapath and the top level.
package pfs_pkg;

   localparam int STACK_DEPTH = 4096;
   localparam int PAGE_SHIFT  = 12;
   localparam int ADDR_BITS   = 48;

   localparam int FRAME_BITS  = ADDR_BITS - PAGE_SHIFT;
   localparam int PTR_BITS    = $clog2(STACK_DEPTH);
   localparam int COUNT_BITS  = PTR_BITS + 1;
   // frame numbers with one spare bit, so the top of the address space fits
   localparam int FRAME_XBITS = FRAME_BITS + 1;

   localparam logic [COUNT_BITS-1:0]  COUNT_FULL  = COUNT_BITS'(STACK_DEPTH);
   localparam logic [FRAME_XBITS-1:0] FRAME_LIMIT = FRAME_XBITS'(1) << FRAME_BITS;

   // request stream packing
   localparam int REQ_FIELD_BITS = 3 * ADDR_BITS + 1;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = ADDR_BITS + COUNT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_ALLOC = 2'd1,
      FUNC_FREE  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_ADD_PREP,
      S_ADD_COUNT,
      S_ADD_RUN,
      S_FREE,
      S_POP_WAIT,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       accept;      // latch request fields
      logic       prep;        // round region bounds
      logic       count;       // work out number of frames
      logic       push_region; // push next region frame
      logic       push_free;   // push freed frame
      logic       pop;         // read top of stack, decrement
      logic       capture;     // take popped frame as result address
      logic       set_status;
      status_type status;
      logic       load_out;    // move result into output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      func_type func;
      logic     usable;
      logic     full;
      logic     empty;
      logic     n_zero;
      logic     out_busy;
   } stat_type;

endpackage

@@ hw/rtl/pfs_ctrl.sv @@
// Sequencer for the page frame free stack: decodes each request and steps
// the datapath through it. Depends on pfs_pkg.
module pfs_ctrl
   import pfs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_fire,
   input  stat_type stat,
   output logic     req_ready,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.status = ST_OK;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.accept = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.func)
               FUNC_ADD:   state_in = stat.usable ? S_ADD_PREP : S_RESP;
               FUNC_FREE:  state_in = S_FREE;
               FUNC_ALLOC: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                     state_in       = S_RESP;
                  end else begin
                     cmd.pop  = 1'b1;
                     state_in = S_POP_WAIT;
                  end
               end
               default:    state_in = S_RESP;
            endcase
         end
         S_ADD_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_ADD_COUNT;
         end
         S_ADD_COUNT: begin
            cmd.count = 1'b1;
            state_in  = S_ADD_RUN;
         end
         S_ADD_RUN: begin
            // one frame a cycle until the region is done or the stack fills
            if (stat.n_zero) begin
               state_in = S_RESP;
            end else if (stat.full) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_FULL;
               state_in       = S_RESP;
            end else begin
               cmd.push_region = 1'b1;
            end
         end
         S_FREE: begin
            if (stat.full) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_FULL;
            end else begin
               cmd.push_free = 1'b1;
            end
            state_in = S_RESP;
         end
         S_POP_WAIT: begin
            cmd.capture = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            // hold until the output register is free
            if (!stat.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

@@ hw/rtl/pfs_dpath.sv @@
// Datapath of the page frame free stack: request registers, region bounds,
// the frame stack memory, the stack count and the output register.
// Depends on pfs_pkg.
module pfs_dpath
   import pfs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic [1:0]               req_tuser,
   input  logic                     rsp_tready,
   output stat_type                 stat,
   output logic                     rsp_tvalid,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [1:0]               rsp_tuser
);

   logic [FRAME_BITS-1:0] stack_mem [STACK_DEPTH];

   func_type              func_ff;
   logic [ADDR_BITS-1:0]  base_ff, length_ff, free_addr_ff;
   logic                  usable_ff;

   logic [FRAME_XBITS-1:0] first_ff, last_ff, n_ff;
   logic [FRAME_BITS-1:0]  cur_ff, rd_data_ff;
   logic [COUNT_BITS-1:0]  count_ff;

   status_type            res_status_ff;
   logic [ADDR_BITS-1:0]  res_addr_ff;

   logic                  out_valid_ff;
   status_type            out_status_ff;
   logic [ADDR_BITS-1:0]  out_addr_ff;
   logic [COUNT_BITS-1:0] out_count_ff;

   logic [ADDR_BITS:0]     end_sum;
   logic [FRAME_XBITS-1:0] first_in, end_frame;
   logic                   push;
   logic [FRAME_BITS-1:0]  push_data;
   logic [COUNT_BITS-1:0]  count_dec;

   assign end_sum   = {1'b0, base_ff} + {1'b0, length_ff};
   assign end_frame = end_sum[ADDR_BITS:PAGE_SHIFT];
   assign first_in  = {1'b0, base_ff[ADDR_BITS-1:PAGE_SHIFT]}
                      + FRAME_XBITS'(|base_ff[PAGE_SHIFT-1:0]);
   assign push      = cmd.push_region | cmd.push_free;
   assign push_data = cmd.push_free ? free_addr_ff[ADDR_BITS-1:PAGE_SHIFT] : cur_ff;
   assign count_dec = count_ff - COUNT_BITS'(1);

   // request fields and region bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff      <= func_type'(req_tuser);
         base_ff      <= req_tdata[ADDR_BITS-1:0];
         length_ff    <= req_tdata[2*ADDR_BITS-1:ADDR_BITS];
         usable_ff    <= req_tdata[2*ADDR_BITS];
         free_addr_ff <= req_tdata[3*ADDR_BITS:2*ADDR_BITS+1];
      end
      if (cmd.prep) begin
         first_ff <= first_in;
         last_ff  <= (end_frame > FRAME_LIMIT) ? FRAME_LIMIT : end_frame;
      end
      if (cmd.count) begin
         n_ff   <= (last_ff > first_ff) ? last_ff - first_ff : '0;
         cur_ff <= first_ff[FRAME_BITS-1:0];
      end else if (cmd.push_region) begin
         n_ff   <= n_ff - FRAME_XBITS'(1);
         cur_ff <= cur_ff + FRAME_BITS'(1);
      end
   end

   // frame stack: one write or one registered read a cycle
   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[count_ff[PTR_BITS-1:0]] <= push_data;
      end
      if (cmd.pop) begin
         rd_data_ff <= stack_mem[count_dec[PTR_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (push) begin
         count_ff <= count_ff + COUNT_BITS'(1);
      end else if (cmd.pop) begin
         count_ff <= count_dec;
      end
   end

   // result of the item in flight
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         res_status_ff <= ST_OK;
         res_addr_ff   <= '0;
      end else begin
         if (cmd.set_status) begin
            res_status_ff <= cmd.status;
         end
         if (cmd.capture) begin
            res_addr_ff <= {rd_data_ff, {PAGE_SHIFT{1'b0}}};
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_status_ff <= res_status_ff;
         out_addr_ff   <= res_addr_ff;
         out_count_ff  <= count_ff;
      end
   end

   assign stat.func     = func_ff;
   assign stat.usable   = usable_ff;
   assign stat.full     = (count_ff == COUNT_FULL);
   assign stat.empty    = (count_ff == '0);
   assign stat.n_zero   = (n_ff == '0);
   assign stat.out_busy = out_valid_ff & ~rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-RSP_FIELD_BITS){1'b0}}, out_count_ff, out_addr_ff};

endmodule

@@ hw/rtl/page_frame_free_stack_core.sv @@
// Page frame free stack, top level: joins the controller and the datapath.
// Depends on pfs_pkg, pfs_ctrl and pfs_dpath.
//
// Keeps free page frame numbers on a 4096-entry last-in first-out stack and
// gives one response per request. An allocate pops and captures the top
// frame (an empty stack answers from dispatch); a free pushes its frame
// unless the stack is full; an unusable add or unknown command answers from
// dispatch. A usable add rounds its region bounds, counts frames, then
// pushes them one per cycle through the single write port of the stack
// memory. A return to idle follows each response before the next request is
// taken; a stalled response holds the block in its response state. Frames
// of an add region go on in ascending order, so the highest ends on top.
// Status 1 marks an allocate on an empty stack, status 2 a full stack with
// frames dropped. The stack memory needs no clearing after reset.
module page_frame_free_stack_core
   import pfs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // region_base[47:0], region_length[95:48], region_usable[96],
   // free_address[144:97], zero fill above
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // func[1:0]
   input  logic [1:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // page_address[47:0], free_count[60:48], zero fill above
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]               rsp_tuser
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_fire;

   assign req_fire = req_tvalid & req_tready;

   pfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .stat      (stat),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   pfs_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
